[sv/cfp_pkg.sv]
`default_nettype none
package cfp_pkg;

  localparam int ELEMENTS_DEF   = 118;
  localparam int COUNT_BITS_DEF = 31;
  localparam int SYM_DEPTH      = 118;

  localparam int ACT_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ANUM_W = 7;
  localparam int STAT_W = 3;
  localparam int OUT_W  = 31;

  typedef enum logic [ACT_W-1:0] {
    ACT_CHAR = 2'd0,
    ACT_END  = 2'd1,
    ACT_READ = 2'd2
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_ERROR  = 3'd1,
    ST_ACCEPT = 3'd2,
    ST_REJECT = 3'd3,
    ST_READ   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_UPPER  = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  // Control from the parser to the count store, one set per accepted beat.
  typedef struct packed {
    logic rd_en;  // issue both reads
    logic a_ok;   // port A address names a real element
    logic b_ok;   // port B address names a real element (read action only)
    logic wr_en;  // commit a count
    logic clr;    // forget all counts (first character of a formula)
  } cfp_mem_ctl_t;

  // Element symbols, first letter in the upper byte, second byte zero if absent.
  localparam logic [15:0] SYMBOLS [SYM_DEPTH] = '{
    {"H", 8'h00}, "He", "Li", "Be", {"B", 8'h00}, {"C", 8'h00}, {"N", 8'h00},
    {"O", 8'h00}, {"F", 8'h00}, "Ne",
    "Na", "Mg", "Al", "Si", {"P", 8'h00}, {"S", 8'h00}, "Cl", "Ar", {"K", 8'h00}, "Ca",
    "Sc", "Ti", {"V", 8'h00}, "Cr", "Mn", "Fe", "Co", "Ni", "Cu", "Zn",
    "Ga", "Ge", "As", "Se", "Br", "Kr", "Rb", "Sr", {"Y", 8'h00}, "Zr",
    "Nb", "Mo", "Tc", "Ru", "Rh", "Pd", "Ag", "Cd", "In", "Sn",
    "Sb", "Te", {"I", 8'h00}, "Xe", "Cs", "Ba", "La", "Ce", "Pr", "Nd",
    "Pm", "Sm", "Eu", "Gd", "Tb", "Dy", "Ho", "Er", "Tm", "Yb",
    "Lu", "Hf", "Ta", {"W", 8'h00}, "Re", "Os", "Ir", "Pt", "Au", "Hg",
    "Tl", "Pb", "Bi", "Po", "At", "Rn", "Fr", "Ra", "Ac", "Th",
    "Pa", {"U", 8'h00}, "Np", "Pu", "Am", "Cm", "Bk", "Cf", "Es", "Fm",
    "Md", "No", "Lr", "Rf", "Db", "Sg", "Bh", "Hs", "Mt", "Ds",
    "Rg", "Cn", "Nh", "Fl", "Mc", "Lv", "Ts", "Og"
  };

  // Parallel compare against the symbol table; zero when nothing matches.
  function automatic logic [ANUM_W-1:0] sym_lookup(input logic [CHAR_W-1:0] a,
                                                   input logic [CHAR_W-1:0] b,
                                                   input int n_el);
    logic [ANUM_W-1:0] n;
    n = '0;
    for (int i = 0; i < SYM_DEPTH; i++) begin
      if (i < n_el && SYMBOLS[i] == {a, b}) n = ANUM_W'(i + 1);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

[sv/cfp_count_mem.sv]
`default_nettype none
module cfp_count_mem import cfp_pkg::*; #(
  parameter int ELEMENTS   = ELEMENTS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int AW         = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cfp_mem_ctl_t          ctl,
  input  wire logic [AW-1:0]         rd_addr_a,
  input  wire logic [AW-1:0]         rd_addr_b,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire logic [COUNT_BITS-1:0] wr_data,
  output logic      [COUNT_BITS-1:0] count_a,
  output logic      [COUNT_BITS-1:0] count_b
);

  logic [COUNT_BITS-1:0] mem [ELEMENTS];
  logic [ELEMENTS-1:0]   valid;
  logic [COUNT_BITS-1:0] rd_a;
  logic [COUNT_BITS-1:0] rd_b;
  logic                  vld_a;
  logic                  vld_b;
  logic                  byp;
  logic [COUNT_BITS-1:0] byp_data;

  // Entries not written since the last clear read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.clr) begin
      valid <= '0;
    end else if (ctl.wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) mem[wr_addr] <= wr_data;
    if (ctl.rd_en) begin
      rd_a <= mem[rd_addr_a];
      rd_b <= mem[rd_addr_b];
    end
  end

  // Forward a write that hits the port A address in the same cycle.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      byp      <= ctl.wr_en && (wr_addr == rd_addr_a);
      byp_data <= wr_data;
      vld_a    <= ctl.a_ok && !ctl.clr && valid[rd_addr_a];
      vld_b    <= ctl.b_ok && valid[rd_addr_b];
    end
  end

  assign count_a = byp ? byp_data : (vld_a ? rd_a : '0);
  assign count_b = vld_b ? rd_b : '0;

endmodule
`default_nettype wire

[sv/chemical_formula_parser.sv]
`default_nettype none
// Channel  Dir  tdata                                   tuser
// s_*      in   [7:0] character, [14:8] elem_num        [1:0] action
// m_*      out  [30:0] atom_sum, [61:31] element_count  [2:0] status
//
// One beat in, one beat out, one beat per cycle sustained while results are
// taken; a result appears in the cycle after its input beat is accepted.
// Per-element counts live in a two-read-port memory: port A prefetches the
// count of the element that the next commit will hit, port B serves reads.
// A commit is a read-modify-write against the prefetched word, with a bypass
// when the write hits the entry being prefetched.
// The output register stalls the input only while it holds an untaken beat.
// Reset (rst, synchronous) clears parse state, the total and all counts.
module chemical_formula_parser import cfp_pkg::*; #(
  parameter int ELEMENTS   = ELEMENTS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [7:0] character, [14:8] elem_num
  input  wire logic [1:0]  s_tuser,   // [1:0] action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [30:0] atom_sum, [61:31] element_count
  output logic [2:0]       m_tuser    // [2:0] status
);

  localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int CW = COUNT_BITS;

  logic                  acc;
  logic [ACT_W-1:0]      act;
  logic [CHAR_W-1:0]     ch;
  logic [ANUM_W-1:0]     anum;

  // Parse state
  phase_t                phase, phase_next;
  logic [CHAR_W-1:0]     first_letter, first_letter_next;
  logic [ANUM_W-1:0]     pend_elem, pend_elem_next;
  logic [CW-1:0]         pend_count, pend_count_next;
  logic                  digits_seen, digits_seen_next;
  logic                  error_flag, error_flag_next;
  logic [CW-1:0]         running_total, running_total_next;
  logic                  new_formula, new_formula_next;

  // Result register
  logic                  out_valid;
  status_t               out_status;
  status_t               status_c;
  logic [OUT_W-1:0]      out_total;

  // Character classes and lookups
  logic                  is_upper, is_lower, is_digit, is_space;
  logic [ANUM_W-1:0]     lk_single, lk_pair;
  logic [3:0]            digit_val;

  // Arithmetic for digit accumulate and commit
  logic [CW-1:0]         acc_src;
  logic [CW+3:0]         dig_sum;
  logic                  dig_ovf;
  logic [CW-1:0]         cmt_cnt;
  logic [CW:0]           tab_sum, tot_sum;
  logic                  cmt_ovf;

  // Count store
  cfp_mem_ctl_t          mctl;
  logic                  wr_en, clr;
  logic [AW-1:0]         rd_addr_a, rd_addr_b, wr_addr;
  logic [CW-1:0]         count_a, count_b;
  logic [ANUM_W-1:0]     anum_m1, pend_m1, pend_next_m1;
  logic                  b_ok;

  assign act  = s_tuser[ACT_W-1:0];
  assign ch   = s_tdata[CHAR_W-1:0];
  assign anum = s_tdata[CHAR_W+ANUM_W-1:CHAR_W];

  assign s_tready = !out_valid || m_tready;
  assign acc      = s_tvalid && s_tready;

  assign is_upper  = ch inside {["A":"Z"]};
  assign is_lower  = ch inside {["a":"z"]};
  assign is_digit  = ch inside {["0":"9"]};
  assign is_space  = (ch == " ") || (ch inside {[8'd9:8'd13]});
  assign digit_val = 4'(ch - "0");

  assign lk_single = sym_lookup(ch, 8'h00, ELEMENTS);
  assign lk_pair   = sym_lookup(first_letter, ch, ELEMENTS);

  // pending*10 + digit; a symbol still held starts the run from zero
  assign acc_src = (phase == PH_DIGITS) ? pend_count : '0;
  assign dig_sum = {1'b0, acc_src, 3'b000} + {3'b000, acc_src, 1'b0} + (CW+4)'(digit_val);
  assign dig_ovf = |dig_sum[CW+3:CW];

  // Commit amount: digits if any, else one; a held symbol always commits one
  assign cmt_cnt = (phase == PH_DIGITS && digits_seen) ? pend_count : CW'(1);
  assign tab_sum = {1'b0, count_a} + {1'b0, cmt_cnt};
  assign tot_sum = {1'b0, running_total} + {1'b0, cmt_cnt};
  assign cmt_ovf = tab_sum[CW] || tot_sum[CW];

  always_comb begin
    logic tail;
    tail               = 1'b0;
    phase_next         = phase;
    first_letter_next  = first_letter;
    pend_elem_next     = pend_elem;
    pend_count_next    = pend_count;
    digits_seen_next   = digits_seen;
    error_flag_next    = error_flag;
    running_total_next = running_total;
    new_formula_next   = new_formula;
    wr_en              = 1'b0;
    clr                = 1'b0;
    status_c           = ST_READ;

    case (action_t'(act))
      ACT_CHAR: begin
        // first character of a formula: drop old counts and total
        if (new_formula) begin
          clr                = 1'b1;
          phase_next         = PH_START;
          first_letter_next  = '0;
          pend_elem_next     = '0;
          pend_count_next    = '0;
          digits_seen_next   = 1'b0;
          error_flag_next    = 1'b0;
          running_total_next = '0;
          new_formula_next   = 1'b0;
        end
        if (!error_flag_next) begin
          case (phase_next)
            PH_UPPER: begin
              if (is_lower) begin
                if (lk_pair == '0) begin
                  error_flag_next = 1'b1;
                end else begin
                  pend_elem_next   = lk_pair;
                  pend_count_next  = '0;
                  digits_seen_next = 1'b0;
                  phase_next       = PH_DIGITS;
                end
              end else if (pend_elem == '0) begin
                error_flag_next = 1'b1;
              end else if (is_digit) begin
                pend_count_next  = dig_sum[CW-1:0];
                digits_seen_next = 1'b1;
                phase_next       = PH_DIGITS;
              end else begin
                pend_count_next  = '0;
                digits_seen_next = 1'b0;
                phase_next       = PH_DIGITS;
                if (cmt_ovf) begin
                  error_flag_next = 1'b1;
                end else begin
                  wr_en              = 1'b1;
                  running_total_next = tot_sum[CW-1:0];
                  tail               = 1'b1;
                end
              end
            end
            PH_DIGITS: begin
              if (is_digit) begin
                if (dig_ovf) begin
                  error_flag_next = 1'b1;
                end else begin
                  pend_count_next  = dig_sum[CW-1:0];
                  digits_seen_next = 1'b1;
                end
              end else if (cmt_ovf) begin
                error_flag_next = 1'b1;
              end else begin
                wr_en              = 1'b1;
                running_total_next = tot_sum[CW-1:0];
                tail               = 1'b1;
              end
            end
            default: tail = 1'b1;
          endcase
          // start of a token: skip whitespace, hold an upper-case letter
          if (tail) begin
            phase_next = PH_START;
            if (is_upper) begin
              first_letter_next = ch;
              pend_elem_next    = lk_single;
              phase_next        = PH_UPPER;
            end else if (!is_space) begin
              error_flag_next = 1'b1;
            end
          end
        end
        status_c = error_flag_next ? ST_ERROR : ST_OK;
      end
      ACT_END: begin
        // commit whatever symbol or digit run is still held
        if (!error_flag && (phase == PH_UPPER || phase == PH_DIGITS)) begin
          if (phase == PH_UPPER && pend_elem == '0) begin
            error_flag_next = 1'b1;
          end else if (cmt_ovf) begin
            error_flag_next = 1'b1;
          end else begin
            wr_en              = 1'b1;
            running_total_next = tot_sum[CW-1:0];
          end
        end
        status_c = (!error_flag_next && running_total_next != '0) ? ST_ACCEPT : ST_REJECT;
        phase_next        = PH_START;
        first_letter_next = '0;
        pend_elem_next    = '0;
        pend_count_next   = '0;
        digits_seen_next  = 1'b0;
        error_flag_next   = 1'b0;
        new_formula_next  = 1'b1;
      end
      default: status_c = ST_READ;
    endcase
  end

  // Addresses: port A follows the element the next commit will touch
  assign pend_m1      = pend_elem - ANUM_W'(1);
  assign pend_next_m1 = pend_elem_next - ANUM_W'(1);
  assign anum_m1      = anum - ANUM_W'(1);
  assign wr_addr      = pend_m1[AW-1:0];
  assign rd_addr_a    = pend_next_m1[AW-1:0];
  assign rd_addr_b    = anum_m1[AW-1:0];
  assign b_ok = (act != ACT_CHAR) && (act != ACT_END) && (anum != '0)
                && (32'(anum) <= ELEMENTS);

  assign mctl.rd_en = acc;
  assign mctl.a_ok  = pend_elem_next != '0;
  assign mctl.b_ok  = b_ok;
  assign mctl.wr_en = acc && wr_en;
  assign mctl.clr   = acc && clr;

  cfp_count_mem #(
    .ELEMENTS   (ELEMENTS),
    .COUNT_BITS (COUNT_BITS),
    .AW         (AW)
  ) u_mem (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mctl),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .wr_addr   (wr_addr),
    .wr_data   (tab_sum[CW-1:0]),
    .count_a   (count_a),
    .count_b   (count_b)
  );

  // Advance parse state on every accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      first_letter  <= '0;
      pend_elem     <= '0;
      pend_count    <= '0;
      digits_seen   <= 1'b0;
      error_flag    <= 1'b0;
      running_total <= '0;
      new_formula   <= 1'b1;
    end else if (acc) begin
      phase         <= phase_next;
      first_letter  <= first_letter_next;
      pend_elem     <= pend_elem_next;
      pend_count    <= pend_count_next;
      digits_seen   <= digits_seen_next;
      error_flag    <= error_flag_next;
      running_total <= running_total_next;
      new_formula   <= new_formula_next;
    end
  end

  // Result register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_status <= status_c;
      out_total  <= OUT_W'(running_total_next);
    end
  end

  // Port B data is zero unless this beat was a read of a known element
  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {2'b00, OUT_W'(count_b), out_total};

endmodule
`default_nettype wire
